### hdl/open_exclusion_lattice_step_macros.svh
// assertion macros shared by the checker of the exclusion lattice block
// expects clk_i and rst_ni in the scope of every use
`ifndef OPEN_EXCLUSION_LATTICE_STEP_MACROS_SVH
`define OPEN_EXCLUSION_LATTICE_STEP_MACROS_SVH

// same-cycle implication, off while in reset
`define OELS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oels assertion failed");

// next-cycle implication, off while in reset
`define OELS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oels assertion failed");

`endif

### hdl/oels_pkg.sv
// types, sizes and codes of the open exclusion lattice block
// no dependencies; used by the cell, the top level and the checker
package oels_pkg;

  localparam int SITES      = 64;
  localparam int LABEL_BITS = 16;

  localparam int IDX_W   = $clog2(SITES);
  localparam int LEN_W   = $clog2(SITES + 1);
  localparam int SITE_W  = 7;
  localparam int FRAC_W  = 16;
  localparam int CNT_W   = 7;
  localparam int OLBL_W  = 16;
  localparam int STEP_W  = 32;
  localparam int CMP_W   = ((LEN_W > SITE_W) ? LEN_W : SITE_W) + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_INS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_REM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MOVE = 3'd5;

  localparam logic [SITE_W-1:0] LEN_RESET = 7'd64;
  localparam logic [FRAC_W-1:0] THR_RESET = 16'h8000;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LEFT    = 3'd1,
    EV_RIGHT   = 3'd2,
    EV_INSERT  = 3'd3,
    EV_REMOVE  = 3'd4,
    EV_PLACED  = 3'd5,
    EV_REFUSED = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    SRC_FRESH = 2'd0,
    SRC_LEFT  = 2'd1,
    SRC_RIGHT = 2'd2
  } src_e;

  typedef struct packed {
    logic set;
    logic clr;
    src_e src;
  } cell_ctrl_t;

  typedef struct packed {
    logic              command;
    logic [SITE_W-1:0] site;
    logic [FRAC_W-1:0] uniform_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0]        hop;
    logic [2:0]               event_res;
    logic [OLBL_W-1:0]        particle_label;
    logic [CNT_W-1:0]         particle_count;
    logic [STEP_W-1:0]        step_number;
    logic signed [STEP_W-1:0] net_flux;
  } out_item_t;

endpackage

### hdl/oels_cell.sv
// one lattice site: occupancy flag and particle label
// depends on oels_pkg; takes a label from a neighbor or the fresh label on set
module oels_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  oels_pkg::cell_ctrl_t          ctrl_i,
  input  logic [oels_pkg::LABEL_BITS-1:0] left_label_i,
  input  logic [oels_pkg::LABEL_BITS-1:0] right_label_i,
  input  logic [oels_pkg::LABEL_BITS-1:0] fresh_label_i,
  output logic                          occ_o,
  output logic [oels_pkg::LABEL_BITS-1:0] label_o,
  output logic [oels_pkg::LABEL_BITS-1:0] sel_label_o
);
  import oels_pkg::*;

  logic                  occ_q, occ_d;
  logic [LABEL_BITS-1:0] label_q, label_d;

  always_comb begin
    occ_d   = occ_q;
    label_d = label_q;
    if (ctrl_i.set) begin
      occ_d = 1'b1;
      case (ctrl_i.src)
        SRC_LEFT:  label_d = left_label_i;
        SRC_RIGHT: label_d = right_label_i;
        default:   label_d = fresh_label_i;
      endcase
    end else if (ctrl_i.clr) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    label_q <= label_d;
  end

  assign occ_o       = occ_q;
  assign label_o     = label_q;
  // leaving particle drives its label onto the or-bus
  assign sel_label_o = ctrl_i.clr ? label_q : '0;

endmodule

### hdl/open_exclusion_lattice_step.sv
// top level of the open exclusion lattice: config registers, step decode, cell row
// depends on oels_pkg and oels_cell
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (oels_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (oels_pkg::out_item_t)
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle unless out stalls; its result is registered in out_q
// a transaction updates at most two cells of the row in the cycle it is accepted
// reset empties every cell at once, so no clearing pass is needed
// input is taken while the output register is empty or is read in the same cycle
module open_exclusion_lattice_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  oels_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output oels_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [oels_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [oels_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import oels_pkg::*;

  logic [SITE_W-1:0] len_q;
  logic [FRAC_W-1:0] lins_q, lrem_q, rins_q, rrem_q, move_q;

  logic [LEN_W-1:0]      count_q, count_d;
  logic [LABEL_BITS-1:0] next_label_q;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [STEP_W-1:0]     flux_q, flux_d;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [SITES-1:0]      occ_w;
  logic [LABEL_BITS-1:0] label_w [SITES];
  logic [LABEL_BITS-1:0] sel_w   [SITES];
  cell_ctrl_t            ctrl_w  [SITES];

  logic [CMP_W-1:0] len_ext, eff_len, len_m1, s;
  logic [IDX_W-1:0] s_ix, sm1_ix, sp1_ix, edge_ix;
  logic             fire, in_range, res_l, res_r, has_left, has_right, go_left;
  logic             occ_s, occ_sm1, occ_sp1, occ_edge;
  logic [FRAC_W-1:0] frac, rem_t, ins_t;

  logic              src_en, dst_en, use_fresh;
  logic [IDX_W-1:0]  src_ix, dst_ix;
  src_e              take;
  event_e            ev;
  logic signed [1:0] hop;
  logic [LABEL_BITS-1:0] src_label, res_label;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      lins_q <= THR_RESET;
      lrem_q <= THR_RESET;
      rins_q <= THR_RESET;
      rrem_q <= THR_RESET;
      move_q <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LENGTH:    len_q  <= cfg_wdata_i[SITE_W-1:0];
        REG_LEFT_INS:  lins_q <= cfg_wdata_i[FRAC_W-1:0];
        REG_LEFT_REM:  lrem_q <= cfg_wdata_i[FRAC_W-1:0];
        REG_RIGHT_INS: rins_q <= cfg_wdata_i[FRAC_W-1:0];
        REG_RIGHT_REM: rrem_q <= cfg_wdata_i[FRAC_W-1:0];
        REG_LEFT_MOVE: move_q <= cfg_wdata_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_ext = CMP_W'(len_q);
    if (len_ext < CMP_W'(2)) begin
      eff_len = CMP_W'(2);
    end else if (len_ext > CMP_W'(SITES)) begin
      eff_len = CMP_W'(SITES);
    end else begin
      eff_len = len_ext;
    end
  end

  assign len_m1    = eff_len - CMP_W'(1);
  assign s         = CMP_W'(in_data_i.site);
  assign frac      = in_data_i.uniform_fraction;
  assign in_range  = s < eff_len;
  assign res_l     = s == eff_len;
  assign res_r     = s == (eff_len + CMP_W'(1));
  assign has_left  = s != '0;
  assign has_right = (s + CMP_W'(1)) < eff_len;
  assign go_left   = frac < move_q;

  assign s_ix    = s[IDX_W-1:0];
  assign sm1_ix  = s_ix - IDX_W'(1);
  assign sp1_ix  = s_ix + IDX_W'(1);
  assign edge_ix = res_l ? '0 : len_m1[IDX_W-1:0];
  assign occ_s    = occ_w[s_ix];
  assign occ_sm1  = occ_w[sm1_ix];
  assign occ_sp1  = occ_w[sp1_ix];
  assign occ_edge = occ_w[edge_ix];
  assign rem_t    = res_l ? lrem_q : rrem_q;
  assign ins_t    = res_l ? lins_q : rins_q;

  always_comb begin
    ev        = EV_NONE;
    hop       = 2'sd0;
    src_en    = 1'b0;
    dst_en    = 1'b0;
    src_ix    = '0;
    dst_ix    = '0;
    take      = SRC_FRESH;
    use_fresh = 1'b0;
    if (in_data_i.command == CMD_PLACE) begin
      if (in_range && !occ_s) begin
        dst_en    = 1'b1;
        dst_ix    = s_ix;
        use_fresh = 1'b1;
        ev        = EV_PLACED;
      end else begin
        ev = EV_REFUSED;
      end
    end else if (res_l || res_r) begin
      if (occ_edge) begin
        if (frac < rem_t) begin
          src_en = 1'b1;
          src_ix = edge_ix;
          ev     = EV_REMOVE;
          hop    = res_l ? -2'sd1 : 2'sd1;
        end
      end else if (frac < ins_t) begin
        dst_en    = 1'b1;
        dst_ix    = edge_ix;
        use_fresh = 1'b1;
        ev        = EV_INSERT;
        hop       = res_l ? 2'sd1 : -2'sd1;
      end
    end else if (in_range) begin
      if (occ_s) begin
        if (go_left && has_left && !occ_sm1) begin
          src_en = 1'b1; src_ix = s_ix;
          dst_en = 1'b1; dst_ix = sm1_ix; take = SRC_RIGHT;
          ev = EV_LEFT; hop = -2'sd1;
        end else if (!go_left && has_right && !occ_sp1) begin
          src_en = 1'b1; src_ix = s_ix;
          dst_en = 1'b1; dst_ix = sp1_ix; take = SRC_LEFT;
          ev = EV_RIGHT; hop = 2'sd1;
        end
      end else begin
        if (go_left && has_right && occ_sp1) begin
          src_en = 1'b1; src_ix = sp1_ix;
          dst_en = 1'b1; dst_ix = s_ix; take = SRC_RIGHT;
          ev = EV_LEFT; hop = -2'sd1;
        end else if (!go_left && has_left && occ_sm1) begin
          src_en = 1'b1; src_ix = sm1_ix;
          dst_en = 1'b1; dst_ix = s_ix; take = SRC_LEFT;
          ev = EV_RIGHT; hop = 2'sd1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < SITES; k++) begin
      ctrl_w[k].set = fire && dst_en && (dst_ix == IDX_W'(k));
      ctrl_w[k].clr = fire && src_en && (src_ix == IDX_W'(k));
      ctrl_w[k].src = take;
    end
  end

  for (genvar k = 0; k < SITES; k++) begin : g_cell
    logic [LABEL_BITS-1:0] left_lbl, right_lbl;
    if (k == 0) begin : g_lo
      assign left_lbl = '0;
    end else begin : g_li
      assign left_lbl = label_w[k-1];
    end
    if (k == SITES - 1) begin : g_ro
      assign right_lbl = '0;
    end else begin : g_ri
      assign right_lbl = label_w[k+1];
    end
    oels_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_w[k]),
      .left_label_i  (left_lbl),
      .right_label_i (right_lbl),
      .fresh_label_i (next_label_q),
      .occ_o         (occ_w[k]),
      .label_o       (label_w[k]),
      .sel_label_o   (sel_w[k])
    );
  end

  always_comb begin
    src_label = '0;
    for (int k = 0; k < SITES; k++) begin
      src_label = src_label | sel_w[k];
    end
  end

  assign res_label = use_fresh ? next_label_q : src_label;

  always_comb begin
    count_d = count_q;
    if (ev == EV_PLACED || ev == EV_INSERT) begin
      count_d = count_q + LEN_W'(1);
    end else if (ev == EV_REMOVE) begin
      count_d = count_q - LEN_W'(1);
    end
    step_d = step_q;
    flux_d = flux_q;
    if (in_data_i.command == CMD_STEP) begin
      step_d = step_q + STEP_W'(1);
      flux_d = flux_q + STEP_W'(hop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      next_label_q <= '0;
      step_q       <= '0;
      flux_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
        step_q  <= step_d;
        flux_q  <= flux_d;
        if (use_fresh) begin
          next_label_q <= next_label_q + LABEL_BITS'(1);
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.hop            <= hop;
      out_q.event_res      <= ev;
      out_q.particle_label <= OLBL_W'(res_label);
      out_q.particle_count <= CNT_W'(count_d);
      out_q.step_number    <= step_d;
      out_q.net_flux       <= flux_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/oels_checker.sv
// port-level checks of the open exclusion lattice block, bound to the top level
// depends on oels_pkg and open_exclusion_lattice_step_macros.svh
`include "open_exclusion_lattice_step_macros.svh"

module oels_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input oels_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input oels_pkg::out_item_t out_data_o
);
  import oels_pkg::*;

  logic still_ev;

  assign still_ev = out_data_o.event_res == EV_NONE || out_data_o.event_res == EV_PLACED ||
                    out_data_o.event_res == EV_REFUSED;

  `OELS_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, $stable(out_data_o))
  `OELS_ASSERT_NEXT(a_accept_gives_result, in_valid_i && in_ready_o, out_valid_o)
  `OELS_ASSERT_IMPL(a_still_no_hop, out_valid_o && still_ev, out_data_o.hop == 2'sd0)
  `OELS_ASSERT_IMPL(a_refused_no_label, out_valid_o && out_data_o.event_res == EV_REFUSED, out_data_o.particle_label == '0)

endmodule

bind open_exclusion_lattice_step oels_checker u_oels_checker (.*);
